// ----- rtl/core/time_series_ramp_detector_defines.svh -----
// Assertion macros for the time series ramp detector.
`ifndef TIME_SERIES_RAMP_DETECTOR_DEFINES_SVH
`define TIME_SERIES_RAMP_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tsrd_pkg.sv -----
// Shared types, constants and functions of the time series ramp detector.
package tsrd_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 31;
  localparam int KIND_W     = 3;
  localparam int CHG_W      = 33;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_EXACT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SECONDS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_KIND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 2'd3;

  localparam logic [KIND_W-1:0] KIND_LT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EQ = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GE = 3'd5;

  localparam logic [STAT_W-1:0] ST_NO_RAMP = 2'd0;
  localparam logic [STAT_W-1:0] ST_RAMP    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_CFG = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd3600;

  typedef struct packed {
    logic              missing;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] stamp;
  } hist_entry_t;

  typedef struct packed {
    logic              clear;
    logic              exact;
    logic              look_up;
    logic              look_down;
    logic [STEP_W-1:0] step;
    logic [TIME_W-1:0] t_now;
  } tsrd_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             have;
    logic [VAL_W-1:0] base;
  } tsrd_sts_t;

  function automatic logic kind_holds(input logic [KIND_W-1:0] kind,
                                      input logic signed [CHG_W-1:0] diff,
                                      input logic signed [CHG_W-1:0] level);
    logic r;
    unique case (kind)
      KIND_LT: r = diff < level;
      KIND_LE: r = diff <= level;
      KIND_EQ: r = diff == level;
      KIND_NE: r = diff != level;
      KIND_GT: r = diff > level;
      default: r = diff >= level;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/time_series_ramp_detector.sv -----
// Time series ramp detector: one request in, one result out, after a scan of the sample ring.
//
// Each accepted request scans the stored history of the current series, oldest entry first,
// one entry per cycle through the single read port of the history memory, then forms the
// change against the baseline, judges it and stores the sample. The scan covers every
// stored entry, up to 64 with a full ring. The next request is taken as soon as the
// previous result sits in the output register, even if it has not been taken yet.
// Configuration may only be written while the block is idle.
module time_series_ramp_detector
  import tsrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // sample_time[31:0], sample_value[63:32]
  input  logic [1:0]            s_axis_tuser,  // series_start[0], value_missing[1]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // value_change[32:0], zero fill[39:33]
  output logic [STAT_W-1:0]     m_axis_tuser   // ramp_status[1:0]
);

`include "time_series_ramp_detector_defines.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic                      exact_mode;
  logic [STEP_W-1:0]         step_seconds;
  logic [KIND_W-1:0]         threshold_kind;
  logic signed [VAL_W-1:0]   threshold_level;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [ADDR_W-1:0]         write_pointer;
  logic [CNT_W-1:0]          fill_count;
  logic [ADDR_W-1:0]         rd_addr;
  logic [CNT_W-1:0]          rd_left;
  logic                      rd_vld;

  logic [TIME_W-1:0]         t_now;
  logic signed [VAL_W-1:0]   v_now;
  logic                      miss_now;
  logic signed [CHG_W-1:0]   change;
  logic                      have;

  logic                      accept;
  logic                      finish;
  logic                      mem_re;
  logic                      mem_we;
  hist_entry_t               mem_wdata;
  hist_entry_t               mem_rdata;
  tsrd_ctl_t                 scan_ctl;
  tsrd_sts_t                 scan_sts;

  logic                      look_up;
  logic                      look_down;
  logic                      cfg_bad;
  logic [STAT_W-1:0]         status;
  logic signed [CHG_W-1:0]   change_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      exact_mode      <= 1'b0;
      step_seconds    <= STEP_RESET;
      threshold_kind  <= KIND_GT;
      threshold_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXACT_MODE:      exact_mode      <= cfg_wdata[0];
        CFG_STEP_SECONDS:    step_seconds    <= cfg_wdata[STEP_W-1:0];
        CFG_THRESHOLD_KIND:  threshold_kind  <= cfg_wdata[KIND_W-1:0];
        default:             threshold_level <= $signed(cfg_wdata[VAL_W-1:0]);
      endcase
    end
  end

  assign look_up   = (threshold_kind == KIND_GT) || (threshold_kind == KIND_GE);
  assign look_down = (threshold_kind == KIND_LT) || (threshold_kind == KIND_LE);
  assign cfg_bad   = (threshold_kind > KIND_GE) || (!exact_mode && !look_up && !look_down);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign finish        = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign mem_re        = (state == S_SCAN) && (rd_left != '0);
  assign mem_we        = finish;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (rd_left == '0) state_next = S_DRAIN;
      S_DRAIN: if (!rd_vld && !scan_sts.busy) state_next = S_CALC;
      S_CALC:  state_next = S_DONE;
      S_DONE:  if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      fill_count    <= '0;
      rd_left       <= '0;
      rd_vld        <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= mem_re;
      if (accept) begin
        if (s_axis_tuser[0]) begin
          write_pointer <= '0;
          fill_count    <= '0;
          rd_left       <= '0;
        end else begin
          rd_left <= fill_count;
        end
      end else if (mem_re) begin
        rd_left <= rd_left - 1'b1;
      end else if (finish) begin
        write_pointer <= write_pointer + 1'b1;
        if (fill_count != CNT_W'(HIST_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr  <= write_pointer - fill_count[ADDR_W-1:0];
      t_now    <= s_axis_tdata[TIME_W-1:0];
      v_now    <= $signed(s_axis_tdata[TIME_W +: VAL_W]);
      miss_now <= s_axis_tuser[1];
    end else if (mem_re) begin
      rd_addr <= rd_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      change <= CHG_W'(v_now) - CHG_W'($signed(scan_sts.base));
      have   <= scan_sts.have;
    end
  end

  assign mem_wdata.missing = miss_now;
  assign mem_wdata.value   = v_now;
  assign mem_wdata.stamp   = t_now;

  tsrd_hist_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_pointer),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  assign scan_ctl.clear     = accept;
  assign scan_ctl.exact     = exact_mode;
  assign scan_ctl.look_up   = look_up;
  assign scan_ctl.look_down = look_down;
  assign scan_ctl.step      = step_seconds;
  assign scan_ctl.t_now     = t_now;

  tsrd_base u_base (
    .clk         (clk),
    .rst         (rst),
    .ctl         (scan_ctl),
    .entry_valid (rd_vld),
    .entry       (mem_rdata),
    .sts         (scan_sts)
  );

  always_comb begin
    priority if (cfg_bad) begin
      status     = ST_BAD_CFG;
      change_out = '0;
    end else if (!have || miss_now) begin
      status     = ST_MISSING;
      change_out = '0;
    end else if (kind_holds(threshold_kind, change, CHG_W'(threshold_level))) begin
      status     = ST_RAMP;
      change_out = change;
    end else begin
      status     = ST_NO_RAMP;
      change_out = change;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= {7'b0, change_out};
      m_axis_tuser <= status;
    end
  end

  `TSRD_ASSERT_NOW(a_no_rw_overlap, clk, rst, mem_we, !mem_re, "history write overlaps a read")
  `TSRD_ASSERT_NEXT(a_result_after_store, clk, rst, mem_we, m_axis_tvalid && (state == S_IDLE), "result not presented after store")
  `TSRD_ASSERT_NOW(a_calc_after_drain, clk, rst, state == S_CALC, !rd_vld && !scan_sts.busy, "baseline read while scan in flight")
  `TSRD_ASSERT_NEXT(a_start_clears, clk, rst, accept && s_axis_tuser[0], (fill_count == '0) && (rd_left == '0), "series start left history")

endmodule

// ----- rtl/core/tsrd_hist_mem.sv -----
// Sample history ring: one synchronous memory, one write and one read port.
module tsrd_hist_mem
  import tsrd_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  hist_entry_t       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output hist_entry_t       rdata
);

  hist_entry_t mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tsrd_base.sv -----
// Baseline search: filters history entries by time offset and keeps min, max or latest.
module tsrd_base
  import tsrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tsrd_ctl_t   ctl,
  input  logic        entry_valid,
  input  hist_entry_t entry,
  output tsrd_sts_t   sts
);

  logic                     s1_vld;
  logic                     s1_hit;
  logic signed [VAL_W-1:0]  s1_val;
  logic                     have;
  logic signed [VAL_W-1:0]  base;
  logic signed [TIME_W:0]   dt;
  logic signed [TIME_W:0]   step_ext;
  logic                     hit;

  always_comb begin
    dt       = $signed({1'b0, ctl.t_now}) - $signed({1'b0, entry.stamp});
    step_ext = $signed({2'b00, ctl.step});
    if (ctl.exact) begin
      hit = !entry.missing && (dt == step_ext);
    end else begin
      hit = !entry.missing && (dt <= step_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit <= hit;
    s1_val <= $signed(entry.value);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have <= 1'b0;
    end else if (s1_vld && s1_hit) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld && s1_hit) begin
      priority if (ctl.exact || !have) begin
        base <= s1_val;
      end else if (ctl.look_up && (s1_val < base)) begin
        base <= s1_val;
      end else if (ctl.look_down && (s1_val > base)) begin
        base <= s1_val;
      end else begin
        base <= base;
      end
    end
  end

  assign sts.busy = s1_vld;
  assign sts.have = have;
  assign sts.base = base;

endmodule

// ----- test/tb_time_series_ramp_detector.sv -----
// Self-checking testbench for the time series ramp detector, driven and scored over its streams.
module tb_time_series_ramp_detector;
  import tsrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic              start;
    logic [TIME_W-1:0] stamp;
    logic [VAL_W-1:0]  value;
    logic              miss;
  } sample_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CHG_W-1:0]  change;
  } ramp_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  time_series_ramp_detector DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor state: a copy of the configuration and of the sample ring.
  logic              cur_exact = 1'b0;
  logic [STEP_W-1:0] cur_step = STEP_RESET;
  logic [KIND_W-1:0] cur_kind = KIND_GT;
  logic [VAL_W-1:0]  cur_level = '0;
  logic [TIME_W-1:0] hist_time [HIST_DEPTH];
  logic [VAL_W-1:0]  hist_val [HIST_DEPTH];
  logic              hist_miss [HIST_DEPTH];
  int                ring_wp = 0;
  int                ring_fill = 0;

  sample_t      pending_samples[$];
  ramp_result_t ramp_expect_q[$];
  sample_t      drv_sample;
  ramp_result_t drv_result;
  ramp_result_t want;
  int           samples_queued = 0;
  int           samples_sent = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           configs_run = 1;
  int           status_seen [4] = '{0, 0, 0, 0};
  int           send_gap = 0;
  int           recv_wait = 0;
  int           hold_left = 0;
  int           hold_requests = 0;
  int           holds_done = 0;
  int           idle_cycles = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(input bit on);
    return on ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic void ramp_predict(input sample_t smp, output ramp_result_t res);
    logic   up, down, have, hit;
    longint base, dt, val, diff, lvl;
    int     idx, k;
    up = (cur_kind == KIND_GT) || (cur_kind == KIND_GE);
    down = (cur_kind == KIND_LT) || (cur_kind == KIND_LE);
    have = 1'b0;
    hit = 1'b0;
    base = 0;
    res.status = ST_MISSING;
    res.change = '0;
    if (smp.start) begin
      ring_wp = 0;
      ring_fill = 0;
    end
    if (cur_kind > KIND_GE || (!cur_exact && !up && !down)) begin
      res.status = ST_BAD_CFG;
    end else begin
      idx = (ring_wp + HIST_DEPTH - ring_fill) % HIST_DEPTH;
      for (k = 0; k < ring_fill; k++) begin
        dt = longint'(smp.stamp) - longint'(hist_time[idx]);
        val = longint'($signed(hist_val[idx]));
        if (!hist_miss[idx]) begin
          if (cur_exact) begin
            if (dt == longint'(cur_step)) begin
              base = val;
              have = 1'b1;
            end
          end else if (dt <= longint'(cur_step)) begin
            if (!have || (up && val < base) || (down && val > base)) begin
              base = val;
              have = 1'b1;
            end
          end
        end
        idx = (idx + 1) % HIST_DEPTH;
      end
      if (have && !smp.miss) begin
        diff = longint'($signed(smp.value)) - base;
        lvl = longint'($signed(cur_level));
        res.change = diff[CHG_W-1:0];
        case (cur_kind)
          KIND_LT: hit = diff < lvl;
          KIND_LE: hit = diff <= lvl;
          KIND_EQ: hit = diff == lvl;
          KIND_NE: hit = diff != lvl;
          KIND_GT: hit = diff > lvl;
          default: hit = diff >= lvl;
        endcase
        res.status = hit ? ST_RAMP : ST_NO_RAMP;
      end
    end
    hist_time[ring_wp] = smp.stamp;
    hist_val[ring_wp] = smp.value;
    hist_miss[ring_wp] = smp.miss;
    ring_wp = (ring_wp + 1) % HIST_DEPTH;
    if (ring_fill < HIST_DEPTH) ring_fill++;
  endfunction

  task automatic push_sample(input logic start, input logic [TIME_W-1:0] stamp,
                             input logic [VAL_W-1:0] value, input logic miss);
    sample_t smp;
    smp.start = start;
    smp.stamp = stamp;
    smp.value = value;
    smp.miss = miss;
    pending_samples.push_back(smp);
    samples_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic apply_config(input logic exact, input logic [STEP_W-1:0] step,
                              input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] level);
    write_reg(CFG_EXACT_MODE, CFG_DATA_W'(exact));
    write_reg(CFG_STEP_SECONDS, CFG_DATA_W'(step));
    write_reg(CFG_THRESHOLD_KIND, CFG_DATA_W'(kind));
    write_reg(CFG_THRESHOLD_LEVEL, level);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_exact = exact;
    cur_step = step;
    cur_kind = kind;
    cur_level = level;
    configs_run++;
  endtask

  task automatic settle_block();
    while (samples_sent != samples_queued || ramp_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: offer pending samples, predict each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        ramp_predict(drv_sample, drv_result);
        ramp_expect_q.push_back(drv_result);
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          drv_sample = pending_samples.pop_front();
          s_axis_tdata <= {drv_sample.value, drv_sample.stamp};
          s_axis_tuser <= {drv_sample.miss, drv_sample.start};
          s_axis_tvalid <= 1'b1;
          send_gap <= draw_wait(gaps_on);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: score each result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        status_seen[m_axis_tuser]++;
        if (ramp_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending: expected none, actual status %0d change %0d",
                   $time, m_axis_tuser, $signed(m_axis_tdata[CHG_W-1:0]));
        end else begin
          want = ramp_expect_q.pop_front();
          if (m_axis_tuser !== want.status) begin
            mismatches++;
            $display("%0t: ramp_status expected %0d actual %0d",
                     $time, want.status, m_axis_tuser);
          end
          if (m_axis_tdata[CHG_W-1:0] !== want.change) begin
            mismatches++;
            $display("%0t: value_change expected %0d actual %0d",
                     $time, $signed(want.change), $signed(m_axis_tdata[CHG_W-1:0]));
          end
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        recv_wait <= draw_wait(stalls_on);
        m_axis_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic              r_exact;
    logic [STEP_W-1:0] r_step;
    logic [KIND_W-1:0] r_kind;
    logic [VAL_W-1:0]  r_level;
    logic [TIME_W-1:0] series_time;
    logic [TIME_W-1:0] stamp;
    logic [VAL_W-1:0]  value;
    logic              start;
    int                inc_max;
    int                phase;
    int                n;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: window, 3600 s, greater than, level zero.
    push_sample(1'b1, 32'd1000, 32'h0000_0000, 1'b0);
    push_sample(1'b0, 32'd1010, 32'h7FFF_FFFF, 1'b0);
    push_sample(1'b0, 32'd1020, 32'h8000_0000, 1'b0);
    push_sample(1'b0, 32'd1030, 32'h0000_0000, 1'b1);
    push_sample(1'b0, 32'd1040, 32'h7FFF_FFFF, 1'b0);
    push_sample(1'b0, 32'd1050, 32'h8000_0000, 1'b0);
    push_sample(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    push_sample(1'b0, 32'd5, 32'h0000_0003, 1'b0);
    push_sample(1'b1, 32'd0, 32'h0000_0004, 1'b0);
    settle_block();

    apply_config(1'b1, '0, KIND_EQ, 32'd0);
    push_sample(1'b1, 32'd100, 32'd7, 1'b0);
    push_sample(1'b0, 32'd100, 32'd7, 1'b0);
    push_sample(1'b0, 32'd100, 32'd9, 1'b0);
    push_sample(1'b0, 32'd101, 32'd3, 1'b0);
    settle_block();

    apply_config(1'b1, 31'h7FFF_FFFF, KIND_NE, 32'h8000_0000);
    push_sample(1'b1, 32'd0, 32'd1, 1'b0);
    push_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
    settle_block();

    // Unsupported kinds, and equality tests in window mode.
    apply_config(1'b0, 31'd10, KIND_W'(6), 32'd0);
    push_sample(1'b1, 32'd0, 32'd0, 1'b0);
    push_sample(1'b0, 32'd1, 32'd1, 1'b0);
    settle_block();
    apply_config(1'b1, 31'd1, KIND_W'(7), 32'd0);
    push_sample(1'b0, 32'd2, 32'd2, 1'b0);
    settle_block();
    apply_config(1'b0, 31'd10, KIND_EQ, 32'd0);
    push_sample(1'b0, 32'd3, 32'd3, 1'b0);
    settle_block();
    apply_config(1'b0, 31'd10, KIND_NE, 32'd0);
    push_sample(1'b0, 32'd4, 32'd4, 1'b0);
    settle_block();

    apply_config(1'b0, 31'h7FFF_FFFF, KIND_LE, 32'h7FFF_FFFF);
    push_sample(1'b1, 32'd50, 32'h7FFF_FFFF, 1'b0);
    push_sample(1'b0, 32'd60, 32'h8000_0000, 1'b0);
    settle_block();

    series_time = '0;
    for (phase = 0; phase < 14; phase++) begin
      r_exact = 1'($urandom_range(0, 1));
      if (r_exact) begin
        r_step = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(0, 6));
        r_kind = KIND_W'($urandom_range(KIND_LT, KIND_GE));
        inc_max = 3;
      end else begin
        case ($urandom_range(0, 3))
          0: r_step = STEP_W'($urandom_range(0, 8));
          3: r_step = STEP_W'($urandom);
          default: r_step = STEP_W'($urandom_range(10, 400));
        endcase
        case ($urandom_range(0, 3))
          0: r_kind = KIND_LT;
          1: r_kind = KIND_LE;
          2: r_kind = KIND_GT;
          default: r_kind = KIND_GE;
        endcase
        inc_max = 20;
      end
      if ($urandom_range(0, 9) == 0) r_kind = KIND_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: r_level = $urandom;
        1: r_level = VAL_W'(int'($urandom_range(0, 4000)) - 2000);
        2: r_level = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: r_level = '0;
      endcase
      gaps_on = (phase % 3) != 1;
      stalls_on = (phase % 4) != 2;
      if (phase == 3) hold_requests <= hold_requests + 1;
      apply_config(r_exact, r_step, r_kind, r_level);
      for (n = 0; n < 100; n++) begin
        start = (phase == 0 && n == 0) || ($urandom_range(0, 119) == 0);
        if (start) begin
          series_time = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
          stamp = series_time;
        end else if ($urandom_range(0, 19) == 0) begin
          stamp = $urandom;
        end else begin
          series_time = series_time + TIME_W'($urandom_range(0, inc_max));
          stamp = series_time;
        end
        case ($urandom_range(0, 3))
          0, 1: value = $urandom;
          2: value = VAL_W'(int'($urandom_range(0, 200)) - 100);
          default: value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        push_sample(start, stamp, value, $urandom_range(0, 7) == 0);
      end
      settle_block();
    end

    $display("%0d samples over %0d configurations, %0d results scored", samples_sent,
             configs_run, results_seen);
    $display("statuses seen: %0d no ramp, %0d ramp, %0d missing, %0d bad config",
             status_seen[ST_NO_RAMP], status_seen[ST_RAMP], status_seen[ST_MISSING],
             status_seen[ST_BAD_CFG]);
    if (mismatches == 0 && ramp_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
